[design/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// shared types and constants for the skinning block
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int unsigned NumBonesDefault = 256;
  localparam int unsigned QuotBits = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDM,
    ST_MUL,
    ST_ACC,
    ST_WCHK,
    ST_DIVS,
    ST_DIVW,
    ST_WMUL,
    ST_ADD,
    ST_OUT
  } state_e;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SKIN = 1'b1;

endpackage

[design/lbs_div.sv]
// ----------------------------------------------------------------------------
// lbs_div
// radix-2 restoring divider for unsigned magnitudes, one quotient bit a cycle
// ----------------------------------------------------------------------------
module lbs_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [lbs_pkg::QuotBits-1:0]         num_i,
  input  logic [lbs_pkg::QuotBits-1:0]         den_i,
  output logic                                 done_o,
  output logic [lbs_pkg::QuotBits-1:0]         quot_o
);

  localparam int unsigned CntW = $clog2(lbs_pkg::QuotBits + 1);

  logic [lbs_pkg::QuotBits-1:0] num_q, num_d, den_q, den_d;
  logic [lbs_pkg::QuotBits:0]   rem_q, rem_d, trial;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         busy_q, busy_d;

  assign trial  = {rem_q[lbs_pkg::QuotBits-1:0], num_q[lbs_pkg::QuotBits-1]};
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = num_q;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CntW'(lbs_pkg::QuotBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          num_d = {num_q[lbs_pkg::QuotBits-2:0], 1'b1};
        end else begin
          rem_d = trial;
          num_d = {num_q[lbs_pkg::QuotBits-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

endmodule

[design/linear_blend_skinning_top.sv]
// ----------------------------------------------------------------------------
// linear_blend_skinning_top
// bone palette skinning with one shared multiplier and a serial divider
// ----------------------------------------------------------------------------
// A load transaction writes one palette element. A skin transaction reads the
// bone's 16 elements from the palette memory one per cycle, runs 12 products
// through the single 33x33 multiplier, checks w, then performs three 64-bit
// divisions on the radix-2 divider, each followed by a weight product and
// accumulate per axis. Results appear on the output register, which holds
// while the next transaction is taken. No clearing pass is needed.
module linear_blend_skinning_top #(
  parameter int unsigned NUM_BONES = lbs_pkg::NumBonesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         bone_index_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [16:0]        weight_i,
  input  logic               last_influence_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               divide_error_o
);

  localparam int unsigned BoneW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
  localparam int unsigned AddrW = BoneW + 4;
  localparam int unsigned QB    = lbs_pkg::QuotBits;

  lbs_pkg::state_e state_q, state_d;

  logic signed [31:0] mem [NUM_BONES*16];
  logic signed [31:0] rdata_q;
  logic [AddrW-1:0]   raddr;

  logic signed [31:0] px_q, py_q, pz_q;
  logic [16:0]        wt_q;
  logic               last_q, bone_ok_q;
  logic [BoneW-1:0]   bone_q;
  logic [3:0]         el_q, el_d;        // element being read
  logic               rd_v_q;
  logic [3:0]         rel_q;             // element held in rdata_q
  logic signed [49:0] t_q [4];
  logic signed [63:0] prod_q;
  logic [3:0]         prel_q;
  logic [1:0]         ax_q;
  logic signed [63:0] acc_q [3];
  logic               err_q;
  logic signed [33:0] qs_q;

  logic               bone_ok;
  logic               in_acc, out_acc;

  assign bone_ok    = {24'd0, bone_index_i} < 32'(NUM_BONES);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == lbs_pkg::ST_IDLE);

  // palette memory
  always_ff @(posedge clk_i) begin
    if (in_acc && req_type_i == lbs_pkg::REQ_LOAD && bone_ok)
      mem[{BoneW'(bone_index_i), element_index_i}] <= element_value_i;
    rdata_q <= mem[raddr];
  end
  assign raddr = {bone_q, el_q};

  // shared multiplier operands
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic signed [31:0] coord;
  always_comb begin
    case (rel_q[3:2])
      2'd0:    coord = px_q;
      2'd1:    coord = py_q;
      default: coord = pz_q;
    endcase
    if (state_q == lbs_pkg::ST_WMUL) begin
      ma = 33'(qs_q);
      mb = {16'd0, wt_q};
    end else begin
      ma = {coord[31], coord};
      mb = {rdata_q[31], rdata_q};
    end
  end
  assign mprod = ma * mb;

  // divider interface
  logic signed [49:0] tsel, tw;
  logic [QB-1:0]      num, den, quot;
  logic               dstart, ddone, neg;
  assign tw   = t_q[3];
  assign tsel = t_q[ax_q];
  assign num  = QB'(((tsel < 0) ? -tsel : tsel)) << 16;
  assign den  = QB'((tw < 0) ? -tw : tw);
  assign neg  = (tsel < 0) != (tw < 0);
  assign dstart = (state_q == lbs_pkg::ST_DIVS);

  lbs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart),
    .num_i   (num),
    .den_i   (den),
    .done_o  (ddone),
    .quot_o  (quot)
  );

  logic signed [33:0] qsat;
  always_comb begin
    if (neg) qsat = (quot > QB'(33'h80000000)) ? -34'sh80000000 : -$signed({1'b0, 33'(quot)});
    else     qsat = (quot > QB'(32'h7FFFFFFF)) ? 34'sh7FFFFFFF : $signed({1'b0, 33'(quot)});
  end

  // saturating accumulate
  logic signed [63:0] add_b, add_a, add_s;
  assign add_a = acc_q[ax_q];
  assign add_b = prod_q >>> 16;
  assign add_s = add_a + add_b;
  logic signed [63:0] add_r;
  always_comb begin
    if (!add_a[63] && !add_b[63] && add_s[63])     add_r = 64'sh7FFFFFFFFFFFFFFF;
    else if (add_a[63] && add_b[63] && !add_s[63]) add_r = {1'b1, 63'd0};
    else                                           add_r = add_s;
  end

  always_comb begin
    state_d = state_q;
    el_d    = el_q;
    unique case (state_q)
      lbs_pkg::ST_IDLE: begin
        el_d = '0;
        if (in_acc && req_type_i == lbs_pkg::REQ_SKIN)
          state_d = bone_ok ? lbs_pkg::ST_RDM : (last_influence_i ? lbs_pkg::ST_OUT
                                                                  : lbs_pkg::ST_IDLE);
      end
      lbs_pkg::ST_RDM: begin
        el_d = el_q + 1'b1;
        if (el_q == 4'd15) state_d = lbs_pkg::ST_MUL;
      end
      lbs_pkg::ST_MUL:  state_d = lbs_pkg::ST_ACC;
      lbs_pkg::ST_ACC:  state_d = lbs_pkg::ST_WCHK;
      lbs_pkg::ST_WCHK:
        state_d = (tw == 0) ? (last_q ? lbs_pkg::ST_OUT : lbs_pkg::ST_IDLE)
                            : lbs_pkg::ST_DIVS;
      lbs_pkg::ST_DIVS: state_d = lbs_pkg::ST_DIVW;
      lbs_pkg::ST_DIVW: if (ddone) state_d = lbs_pkg::ST_WMUL;
      lbs_pkg::ST_WMUL: state_d = lbs_pkg::ST_ADD;
      lbs_pkg::ST_ADD:
        state_d = (ax_q == 2'd2) ? (last_q ? lbs_pkg::ST_OUT : lbs_pkg::ST_IDLE)
                                 : lbs_pkg::ST_DIVS;
      lbs_pkg::ST_OUT:  if (!out_valid_o) state_d = lbs_pkg::ST_IDLE;
      default:          state_d = lbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbs_pkg::ST_IDLE;
      el_q        <= '0;
      rd_v_q      <= 1'b0;
      ax_q        <= '0;
      err_q       <= 1'b0;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
      acc_q[2]    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      el_q    <= el_d;
      rd_v_q  <= (state_q == lbs_pkg::ST_RDM);
      if (out_acc) out_valid_o <= 1'b0;
      if (state_q == lbs_pkg::ST_WCHK) begin
        ax_q <= '0;
        if (tw == 0) err_q <= 1'b1;
      end
      if (state_q == lbs_pkg::ST_ADD) begin
        acc_q[ax_q] <= add_r;
        ax_q        <= ax_q + 1'b1;
      end
      if (state_q == lbs_pkg::ST_OUT && !out_valid_o) begin
        out_valid_o <= 1'b1;
        acc_q[0]    <= '0;
        acc_q[1]    <= '0;
        acc_q[2]    <= '0;
        err_q       <= 1'b0;
      end
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF)        return 32'sh7FFFFFFF;
    else if (v < -64'sh80000000)  return 32'sh80000000;
    else                          return v[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q      <= pos_x_i;
      py_q      <= pos_y_i;
      pz_q      <= pos_z_i;
      wt_q      <= weight_i;
      last_q    <= last_influence_i;
      bone_q    <= BoneW'(bone_index_i);
      bone_ok_q <= bone_ok;
    end
    rel_q  <= el_q;
    prel_q <= rel_q;
    if (state_q == lbs_pkg::ST_RDM && el_q == 4'd0) begin
      t_q[0] <= '0; t_q[1] <= '0; t_q[2] <= '0; t_q[3] <= '0;
    end
    // each product lands in prod_q the cycle after its element, summed the cycle after
    if (rd_v_q) begin
      if (rel_q[3:2] == 2'd3) t_q[rel_q[1:0]] <= t_q[rel_q[1:0]] + 50'(rdata_q);
      else                    prod_q <= 64'(mprod);
    end
    if ((rd_v_q || state_q == lbs_pkg::ST_MUL) && prel_q[3:2] != 2'd3 &&
        (state_q == lbs_pkg::ST_RDM || state_q == lbs_pkg::ST_MUL) && el_q >= 4'd2 ||
        state_q == lbs_pkg::ST_MUL && prel_q[3:2] != 2'd3)
      t_q[prel_q[1:0]] <= t_q[prel_q[1:0]] + 50'(prod_q >>> 16);
    if (state_q == lbs_pkg::ST_DIVW && ddone) qs_q <= qsat;
    if (state_q == lbs_pkg::ST_WMUL) prod_q <= 64'(mprod);
    if (state_q == lbs_pkg::ST_OUT && !out_valid_o) begin
      out_x_o        <= sat32(acc_q[0]);
      out_y_o        <= sat32(acc_q[1]);
      out_z_o        <= sat32(acc_q[2]);
      divide_error_o <= err_q;
    end
  end

  // the bone check is sampled with the transaction and must hold through the sequence
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lbs_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("accepted while busy");

  a_div_only_valid_bone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dstart |-> bone_ok_q)
    else $error("division for out of range bone");

  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == lbs_pkg::ST_OUT))
    else $error("result without sequence");

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for linear_blend_skinning_top: palette loads and skin
// transactions, a directed table followed by random vertices, with every
// result checked against a typed expectation or a bit-exact predictor of the blend
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NumItems   = 550;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainWait  = 300;

  typedef struct {
    logic              req;
    logic [7:0]        bone;
    logic [3:0]        elem;
    logic signed [31:0] val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]       wt;
    logic              last;
    bit                typed;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] ez;
    logic              eerr;
  } stim_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic              err;
  } blend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = lbs_pkg::REQ_LOAD;
  logic [7:0] bone_index_i = '0;
  logic [3:0] element_index_i = '0;
  logic signed [31:0] element_value_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic [16:0] weight_i = '0;
  logic last_influence_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic divide_error_o;

  linear_blend_skinning_top dut (.*);

  // predictor state
  logic signed [31:0] bone_mat [256][16];
  bit [15:0] bone_written [256];
  int loaded_bones [$];
  longint blend_acc [3];
  bit blend_err;

  blend_t blend_q [$];
  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit out_quiet = 1'b0;
  stim_t dir_tab [24];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat_add64(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s[63:0]);
  endfunction

  function automatic longint div_sat(longint t, longint w);
    logic [63:0] mt, mw, q;
    mt = (t < 0) ? 64'(-t) : 64'(t);
    mw = (w < 0) ? 64'(-w) : 64'(w);
    q = (mt << 16) / mw;
    if ((t < 0) != (w < 0)) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return longint'(q);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // advance the predictor by one transaction, returns 1 when a blend is due
  function automatic bit skin_step(input stim_t s, output blend_t r);
    longint t [4];
    longint p [3];
    longint wt;
    int c, k;
    r = '{default: '0};
    if (s.req == lbs_pkg::REQ_LOAD) begin
      bone_mat[s.bone][s.elem] = s.val;
      return 1'b0;
    end
    p[0] = longint'(s.px);
    p[1] = longint'(s.py);
    p[2] = longint'(s.pz);
    wt = longint'({47'b0, s.wt});
    for (c = 0; c < 4; c++) begin
      t[c] = longint'(bone_mat[s.bone][12 + c]);
      for (k = 0; k < 3; k++)
        t[c] += (p[k] * longint'(bone_mat[s.bone][k * 4 + c])) >>> 16;
    end
    if (t[3] == 0) begin
      blend_err = 1'b1;
    end else begin
      for (k = 0; k < 3; k++)
        blend_acc[k] = sat_add64(blend_acc[k], (div_sat(t[k], t[3]) * wt) >>> 16);
    end
    if (!s.last) return 1'b0;
    r.x = sat32(blend_acc[0]);
    r.y = sat32(blend_acc[1]);
    r.z = sat32(blend_acc[2]);
    r.err = blend_err;
    blend_acc = '{0, 0, 0};
    blend_err = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_t mk_load(int b, int e, int v);
    stim_t s;
    s = '{default: '0};
    s.req = lbs_pkg::REQ_LOAD;
    s.bone = 8'(b);
    s.elem = 4'(e);
    s.val = v;
    s.px = $urandom;
    s.wt = 17'($urandom);
    s.last = 1'($urandom);
    return s;
  endfunction

  function automatic stim_t mk_skin(int b, int x, int y, int z, int w, bit l);
    stim_t s;
    s = '{default: '0};
    s.req = lbs_pkg::REQ_SKIN;
    s.bone = 8'(b);
    s.elem = 4'($urandom);
    s.val = $urandom;
    s.px = x;
    s.py = y;
    s.pz = z;
    s.wt = 17'(w);
    s.last = l;
    return s;
  endfunction

  task automatic send_item(input stim_t s);
    blend_t r;
    int gap;
    req_type_i <= s.req;
    bone_index_i <= s.bone;
    element_index_i <= s.elem;
    element_value_i <= s.val;
    pos_x_i <= s.px;
    pos_y_i <= s.py;
    pos_z_i <= s.pz;
    weight_i <= s.wt;
    last_influence_i <= s.last;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (s.req == lbs_pkg::REQ_LOAD) begin
      bone_written[s.bone][s.elem] = 1'b1;
      if (bone_written[s.bone] == 16'hFFFF && !(s.bone inside {loaded_bones}))
        loaded_bones.insert(loaded_bones.size(), int'(s.bone));
    end
    if (skin_step(s, r)) begin
      if (s.typed) begin
        r.x = s.ex;
        r.y = s.ey;
        r.z = s.ez;
        r.err = s.eerr;
      end
      blend_q.insert(blend_q.size(), r);
    end
    items_sent++;
    // back-to-back stretch with no idle gaps in the middle of the run
    gap = (items_sent inside {[200:320]} || $urandom_range(99) >= 20) ? 0
        : $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // fill a whole bone matrix in one of several flavours
  task automatic load_bone(int b);
    int style, e, v;
    style = $urandom_range(3);
    for (e = 0; e < 16; e++) begin
      case (style)
        0: v = $urandom;
        1: v = ((e % 5) == 0 ? 65536 : 0) + $signed($urandom_range(8191)) - 4096;
        2: v = (e inside {3, 7, 11}) ? 0 : (e == 15) ? $urandom_range(196608, 16384)
             : $signed($urandom_range(262143)) - 131072;
        default: v = (e inside {3, 7, 11, 15}) ? 0 : $urandom;
      endcase
      send_item(mk_load(b, e, v));
    end
  endtask

  function automatic int rand_pos();
    return ($urandom_range(3) == 0) ? int'($urandom)
         : $signed($urandom_range(2097151)) - 1048576;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= out_quiet || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    blend_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blend_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h err=%b", $realtime,
                 out_x_o, out_y_o, out_z_o, divide_error_o);
        errors++;
      end else begin
        e = blend_q.pop_front();
        if (out_x_o !== e.x) begin
          $display("%0t: out_x exp %h act %h", $realtime, e.x, out_x_o);
          errors++;
        end
        if (out_y_o !== e.y) begin
          $display("%0t: out_y exp %h act %h", $realtime, e.y, out_y_o);
          errors++;
        end
        if (out_z_o !== e.z) begin
          $display("%0t: out_z exp %h act %h", $realtime, e.z, out_z_o);
          errors++;
        end
        if (divide_error_o !== e.err) begin
          $display("%0t: divide_error exp %b act %b", $realtime, e.err, divide_error_o);
          errors++;
        end
      end
    end
  end

  // watchdog on transactions on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int i, n, k, b;
    stim_t s;
    blend_acc = '{0, 0, 0};
    blend_err = 1'b0;
    foreach (bone_written[j]) bone_written[j] = '0;

    // identity on bone 0, diagonal at elements 0, 5, 10 and 15
    for (i = 0; i < 16; i++) dir_tab[i] = mk_load(0, i, (i % 5) == 0 ? 65536 : 0);
    dir_tab[16] = mk_skin(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 65536, 1'b1);
    dir_tab[16].typed = 1'b1;
    dir_tab[16].ex = 32'sh7FFF_FFFF;
    dir_tab[16].ey = 32'sh8000_0000;
    dir_tab[16].ez = 0;
    dir_tab[16].eerr = 1'b0;
    dir_tab[17] = mk_skin(0, 123456, -98765, 32'sh7FFF_FFFF, 0, 1'b0);
    dir_tab[18] = mk_skin(0, 65536, -65536, 131072, 65536, 1'b0);
    dir_tab[19] = mk_skin(0, -300000, 77777, -1, 131071, 1'b1);
    // zero w drops the influence and flags it
    dir_tab[20] = mk_load(0, 15, 0);
    dir_tab[21] = mk_skin(0, 65536, 65536, 65536, 65536, 1'b1);
    dir_tab[21].typed = 1'b1;
    dir_tab[21].ex = 0;
    dir_tab[21].ey = 0;
    dir_tab[21].ez = 0;
    dir_tab[21].eerr = 1'b1;
    dir_tab[22] = mk_load(0, 15, 32'sh8000_0000);
    dir_tab[23] = mk_skin(0, -65536, 32'sh7FFF_FFFF, 5, 65535, 1'b1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[j]) send_item(dir_tab[j]);

    load_bone(255);
    load_bone($urandom_range(254, 1));
    while (items_sent < NumItems) begin
      k = $urandom_range(99);
      out_quiet = (items_sent inside {[250:350]});
      if (k < 8 && loaded_bones.size() < 24) begin
        load_bone($urandom_range(255));
      end else if (k < 15) begin
        // stray element write, possibly leaving a bone half written
        b = (k < 11) ? loaded_bones[$urandom_range(loaded_bones.size() - 1)]
                     : $urandom_range(255);
        send_item(mk_load(b, $urandom_range(15), $urandom));
      end else begin
        n = $urandom_range(4, 1);
        for (i = 0; i < n; i++) begin
          s = mk_skin(loaded_bones[$urandom_range(loaded_bones.size() - 1)],
                      rand_pos(), rand_pos(), rand_pos(),
                      ($urandom_range(9) == 0) ? $urandom_range(131071)
                                                : $urandom_range(65536),
                      (i == n - 1) ? 1'b1 : ($urandom_range(15) == 0));
          send_item(s);
        end
      end
    end
    // close any open vertex so its blend comes out
    send_item(mk_skin(loaded_bones[0], rand_pos(), rand_pos(), rand_pos(), 65536, 1'b1));
    in_valid_i <= 1'b0;

    while (blend_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
